// ===== hdl/pidl_pkg.sv =====
// Package for the positional insert/delete list: sizes, codes and cell command type.
package pidl_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int POS_W = 5;
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_PAST_END = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic [IDX_W-1:0]  at;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

// ===== hdl/positional_insert_delete_list_core.sv =====
// Top level of the positional insert/delete list: cell row, count and result register.
//
//  channel | direction | handshake                  | fields
//  in      | input     | in_valid_i / in_stall_o    | action_i, value_i, position_i
//  out     | output    | out_valid_o / out_stall_i  | removed_value_o, status_o, entry_count_o
//
// All cells shift in parallel at the accepting edge and the result is registered on
// that same edge, so one item per cycle is sustained while no result is held by out_stall_i.
// Reset clears the count and the result valid; slot contents are left as they are.
// in_stall_o rises only while a result waits and out_stall_i holds it.
module positional_insert_delete_list_core
  import pidl_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               action_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [POS_W-1:0]         position_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] removed_value_o,
  output logic [1:0]               status_o,
  output logic [CNT_W-1:0]         entry_count_o
);

  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] removed_q, removed_d;
  status_e           status_q, status_d;
  logic [CNT_W-1:0]  ecount_q;

  logic              in_acc;
  cell_cmd_t         cmd;
  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [CMP_W-1:0]  pos_x, cnt_x;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pos_x      = CMP_W'(position_i);
  assign cnt_x      = CMP_W'(count_q);

  always_comb begin
    cmd.op    = CELL_HOLD;
    cmd.at    = IDX_W'(position_i);
    cmd.value = value_i;
    count_d   = count_q;
    removed_d = '0;
    status_d  = ST_OK;
    if (in_acc) begin
      case (action_i)
        ACT_INSERT: begin
          if (count_q == CNT_W'(DEPTH)) begin
            status_d = ST_FULL;
          end else begin
            cmd.op  = CELL_INS;
            // past the end appends
            cmd.at  = (pos_x < cnt_x) ? IDX_W'(position_i) : IDX_W'(count_q);
            count_d = count_q + 1'b1;
          end
        end
        ACT_DELETE: begin
          if (count_q == '0) begin
            status_d = ST_EMPTY;
          end else if (pos_x >= cnt_x) begin
            status_d = ST_PAST_END;
          end else begin
            cmd.op    = CELL_DEL;
            removed_d = cell_data[IDX_W'(position_i)];
            count_d   = count_q - 1'b1;
          end
        end
        ACT_CLEAR: count_d = '0;
        default:   count_d = count_q;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = cell_data[0];
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = cell_data[g];
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end
    pidl_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(g)),
      .cmd_i   (cmd),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      removed_q <= removed_d;
      status_q  <= status_d;
      ecount_q  <= count_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign removed_value_o = removed_q;
  assign status_o        = status_q;
  assign entry_count_o   = ecount_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("list count above depth");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && action_i == ACT_INSERT && count_q != CNT_W'(DEPTH)
    |=> entry_count_o == CNT_W'($past(count_q) + 1'b1) && count_q == entry_count_o)
    else $error("insert did not grow the list by one");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == ST_FULL |-> entry_count_o == CNT_W'(DEPTH))
    else $error("full status with list not full");

  a_removed_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && removed_q != '0 |-> status_q == ST_OK)
    else $error("removed word reported on a failed item");

endmodule

// ===== hdl/pidl_cell.sv =====
// One list slot: holds a word and shifts it to or from its neighbors.
module pidl_cell
  import pidl_pkg::*;
(
  input  logic              clk_i,
  input  logic [IDX_W-1:0]  idx_i,
  input  cell_cmd_t         cmd_i,
  input  logic [DATA_W-1:0] left_i,
  input  logic [DATA_W-1:0] right_i,
  output logic [DATA_W-1:0] data_o
);

  logic [DATA_W-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    case (cmd_i.op)
      CELL_INS: begin
        if (idx_i > cmd_i.at) begin
          data_d = left_i;
        end else if (idx_i == cmd_i.at) begin
          data_d = cmd_i.value;
        end
      end
      CELL_DEL: begin
        // slots at and above the removed one pull from the right
        if (idx_i >= cmd_i.at) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== tb/sv/pidl_list_checker.sv =====
// Checker for the positional insert/delete list: watches both channels, predicts and compares.
module pidl_list_checker
  import pidl_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic [1:0]               action_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic signed [DATA_W-1:0] removed_value_i,
  input  logic [1:0]               status_i,
  input  logic [CNT_W-1:0]         entry_count_i,
  output int                       fail_count_o,
  output int                       pending_o
);

  typedef struct packed {
    logic signed [DATA_W-1:0] removed_value;
    status_e                  status;
    logic [CNT_W-1:0]         entry_count;
  } list_result_t;

  // predicted list contents and fill level
  logic signed [DATA_W-1:0] list_slots [DEPTH];
  int                       list_count;
  list_result_t             pending_results [$];
  int                       fail_total;

  assign fail_count_o = fail_total;

  function automatic list_result_t apply_list_op(input logic [1:0] act,
                                                 input logic signed [DATA_W-1:0] word,
                                                 input logic [POS_W-1:0] pos);
    list_result_t res;
    int           at;
    res.removed_value = '0;
    res.status        = ST_OK;
    case (act)
      ACT_INSERT: begin
        if (list_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // past the end the word is appended
          at = (int'(pos) < list_count) ? int'(pos) : list_count;
          for (int i = list_count; i > at; i--) list_slots[i] = list_slots[i-1];
          list_slots[at] = word;
          list_count++;
        end
      end
      ACT_DELETE: begin
        if (list_count == 0) begin
          res.status = ST_EMPTY;
        end else if (int'(pos) >= list_count) begin
          res.status = ST_PAST_END;
        end else begin
          res.removed_value = list_slots[pos];
          for (int i = int'(pos); i + 1 < list_count; i++) list_slots[i] = list_slots[i+1];
          list_count--;
        end
      end
      ACT_CLEAR: begin
        list_count = 0;
      end
      default: begin
        // unused code: no change
      end
    endcase
    res.entry_count = list_count[CNT_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t got;
    list_result_t want;
    if (!rst_ni) begin
      list_count = 0;
      pending_results.delete();
      fail_total = 0;
      pending_o  = 0;
    end else begin
      // check the outgoing item first so an early result cannot match its own prediction
      if (out_valid_i && !out_stall_i) begin
        got.removed_value = removed_value_i;
        got.status        = status_e'(status_i);
        got.entry_count   = entry_count_i;
        if (pending_results.size() == 0) begin
          $error("unexpected result: removed_value %0d status %0d entry_count %0d",
                 removed_value_i, status_i, entry_count_i);
          fail_total++;
        end else begin
          want = pending_results.pop_front();
          if (got.removed_value !== want.removed_value) begin
            $error("removed_value: expected %0d, got %0d", want.removed_value,
                   got.removed_value);
            fail_total++;
          end
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            fail_total++;
          end
          if (got.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   got.entry_count);
            fail_total++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        pending_results.push_back(apply_list_op(action_i, value_i, position_i));
      end
      pending_o = pending_results.size();
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the list regression: clock, reset, stimulus, stall pattern and verdict.
module testbench;
  import pidl_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         ITEMS_PER_PHASE = 362;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               list_action = ACT_INSERT;
  logic signed [DATA_W-1:0] list_value = '0;
  logic [POS_W-1:0]         list_position = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] removed_value;
  logic [1:0]               list_status;
  logic [CNT_W-1:0]         entry_count;
  int                       fail_count;
  int                       pending_count;
  int                       cycle_count = 0;
  int                       idle_pct = 0;
  int                       stall_pct = 0;

  positional_insert_delete_list_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .action_i       (list_action),
    .value_i        (list_value),
    .position_i     (list_position),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .removed_value_o(removed_value),
    .status_o       (list_status),
    .entry_count_o  (entry_count)
  );

  pidl_list_checker list_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .action_i       (list_action),
    .value_i        (list_value),
    .position_i     (list_position),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .removed_value_i(removed_value),
    .status_i       (list_status),
    .entry_count_i  (entry_count),
    .fail_count_o   (fail_count),
    .pending_o      (pending_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("positional_insert_delete_list_core regression: fail");
      $finish;
    end
  end

  // present one item and hold it until the block takes it
  task automatic send_item(input logic [1:0] act, input logic signed [DATA_W-1:0] word,
                           input logic [POS_W-1:0] pos);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    list_action   <= act;
    list_value    <= word;
    list_position <= pos;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic send_random(input int ins_bias, output bit counted);
    int                       pick;
    logic [1:0]               act;
    logic signed [DATA_W-1:0] word;
    logic [POS_W-1:0]         pos;
    pick = $urandom_range(99);
    if (pick < 2)                 act = ACT_UNUSED;
    else if (pick < 5)            act = ACT_CLEAR;
    else if (pick < 5 + ins_bias) act = ACT_INSERT;
    else                          act = ACT_DELETE;
    pick = $urandom_range(99);
    if (pick < 40)      pos = POS_W'($urandom_range(0, DEPTH));
    else if (pick < 70) pos = POS_W'($urandom_range(0, 3));
    else if (pick < 85) pos = POS_W'($urandom_range(DEPTH - 4, DEPTH));
    else                pos = POS_W'($urandom_range(0, 31));
    case ($urandom_range(19))
      0:       word = 32'sh7fffffff;
      1:       word = 32'sh80000000;
      2:       word = '0;
      3:       word = -32'sd1;
      default: word = $urandom;
    endcase
    send_item(act, word, pos);
    counted = (act != ACT_UNUSED);
  endtask

  initial begin
    int phase_idle [4];
    int phase_stall [4];
    int sent;
    int ins_bias;
    bit counted;
    phase_idle  = '{0, 47, 0, 17};
    phase_stall = '{0, 0, 47, 17};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: corner statuses, clamped insert, extremes, fill to full
    send_item(ACT_DELETE, 32'sd5, 5'd0);
    send_item(ACT_INSERT, 32'sh7fffffff, 5'd0);
    send_item(ACT_INSERT, 32'sh80000000, 5'd31);
    send_item(ACT_INSERT, -32'sd1, 5'd1);
    send_item(ACT_DELETE, '0, 5'd3);
    send_item(ACT_DELETE, '0, 5'd1);
    send_item(ACT_UNUSED, 32'sh5a5a5a5a, 5'd21);
    send_item(ACT_CLEAR, 32'sh12345678, 5'd10);
    for (int i = 0; i < DEPTH; i++) begin
      send_item(ACT_INSERT, $urandom, POS_W'($urandom_range(0, 31)));
    end
    send_item(ACT_INSERT, 32'sd77, 5'd0);
    send_item(ACT_DELETE, '0, 5'd15);
    send_item(ACT_CLEAR, '0, 5'd0);

    for (int p = 0; p < 4; p++) begin
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      sent      = 0;
      ins_bias  = 50;
      while (sent < ITEMS_PER_PHASE) begin
        // drift the insert share so the list wanders between empty and full
        if (sent % 40 == 0) ins_bias = $urandom_range(25, 70);
        send_random(ins_bias, counted);
        if (counted) sent++;
      end
    end

    in_valid  <= 1'b0;
    stall_pct = 0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("positional_insert_delete_list_core regression: pass");
    end else begin
      $display("positional_insert_delete_list_core regression: fail");
    end
    $finish;
  end

endmodule
